>>> sv/fbq_pkg.sv
`default_nettype none

package fbq_pkg;

    localparam int DEPTH     = 128;
    localparam int KEY_BITS  = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int MAX_W     = 8;
    localparam int MAX_RESET = 100;
    localparam int KIND_W    = 2;
    localparam int STAT_W    = 2;
    localparam int S_DATA_W  = ((3 * KEY_BITS + 7) / 8) * 8;
    localparam int M_DATA_W  = ((3 * KEY_BITS + CNT_W + 7) / 8) * 8;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND   = 2'd0,
        KIND_PRIORITY = 2'd1,
        KIND_POP      = 2'd2,
        KIND_CANCEL   = 2'd3
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SEARCH,
        S_SHIFT,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] plate;
        logic [KEY_BITS-1:0] model;
        logic [KEY_BITS-1:0] name;
    } entry_t;

    typedef struct packed {
        status_t status;
        entry_t  removed;
        cnt_t    count;
    } result_t;

endpackage

`default_nettype wire

>>> sv/fbq_ram.sv
`default_nettype none

module fbq_ram #(
    parameter int WIDTH = 96,
    parameter int WORDS = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(WORDS)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(WORDS)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [WORDS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/fbq_ctrl.sv
`default_nettype none

module fbq_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic [fbq_pkg::MAX_W-1:0]   cfg_wdata,
    input  wire logic                        in_valid,
    output      logic                        in_ready,
    input  wire fbq_pkg::kind_t              in_kind,
    input  wire fbq_pkg::entry_t             in_key,
    output      logic                        res_valid,
    input  wire logic                        res_ready,
    output      fbq_pkg::result_t            res,
    output      logic                        ram_we,
    output      fbq_pkg::idx_t               ram_waddr,
    output      fbq_pkg::entry_t             ram_wdata,
    output      logic                        ram_re,
    output      fbq_pkg::idx_t               ram_raddr,
    input  wire fbq_pkg::entry_t             ram_rdata
);

    fbq_pkg::state_t  state_reg, state_next;
    fbq_pkg::idx_t    head_reg, head_next;
    fbq_pkg::cnt_t    count_reg, count_next;
    fbq_pkg::cnt_t    cur_reg, cur_next;
    logic [fbq_pkg::MAX_W-1:0] max_reg;
    fbq_pkg::entry_t  key_reg, key_next;
    fbq_pkg::status_t status_reg, status_next;
    fbq_pkg::entry_t  gone_reg, gone_next;

    fbq_pkg::cnt_t    limit;
    logic             full;
    logic             accept;
    logic             match;
    logic             more_search;
    logic             more_shift;
    logic [fbq_pkg::CNT_W:0] cur_plus1;
    logic [fbq_pkg::CNT_W:0] cur_plus2;
    fbq_pkg::idx_t    cur_idx;

    always_comb begin
        if (max_reg == '0) begin
            limit = fbq_pkg::cnt_t'(1);
        end else if (int'(max_reg) > fbq_pkg::DEPTH) begin
            limit = fbq_pkg::cnt_t'(fbq_pkg::DEPTH);
        end else begin
            limit = fbq_pkg::cnt_t'(max_reg);
        end
    end

    assign full        = (count_reg != '0) && (count_reg >= limit);
    assign in_ready    = (state_reg == fbq_pkg::S_IDLE);
    assign accept      = in_valid && in_ready;
    assign match       = (ram_rdata == key_reg);
    assign cur_plus1   = {1'b0, cur_reg} + (fbq_pkg::CNT_W+1)'(1);
    assign cur_plus2   = {1'b0, cur_reg} + (fbq_pkg::CNT_W+1)'(2);
    assign more_search = cur_plus1 < {1'b0, count_reg};
    assign more_shift  = cur_plus2 < {1'b0, count_reg};
    assign cur_idx     = cur_reg[fbq_pkg::IDX_W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fbq_pkg::S_IDLE: begin
                if (accept) begin
                    if ((in_kind == fbq_pkg::KIND_POP) && (count_reg != '0)) begin
                        state_next = fbq_pkg::S_POP;
                    end else if ((in_kind == fbq_pkg::KIND_CANCEL) && (count_reg != '0)) begin
                        state_next = fbq_pkg::S_SEARCH;
                    end else begin
                        state_next = fbq_pkg::S_RESULT;
                    end
                end
            end
            fbq_pkg::S_POP: state_next = fbq_pkg::S_RESULT;
            fbq_pkg::S_SEARCH: begin
                if (match) begin
                    state_next = more_search ? fbq_pkg::S_SHIFT : fbq_pkg::S_RESULT;
                end else if (!more_search) begin
                    state_next = fbq_pkg::S_RESULT;
                end
            end
            fbq_pkg::S_SHIFT: begin
                if (!more_shift) begin
                    state_next = fbq_pkg::S_RESULT;
                end
            end
            fbq_pkg::S_RESULT: begin
                if (res_ready) begin
                    state_next = fbq_pkg::S_IDLE;
                end
            end
            default: state_next = fbq_pkg::S_IDLE;
        endcase
    end

    // datapath and memory access
    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        cur_next    = cur_reg;
        key_next    = key_reg;
        status_next = status_reg;
        gone_next   = gone_reg;
        ram_we      = 1'b0;
        ram_waddr   = head_reg;
        ram_wdata   = in_key;
        ram_re      = 1'b0;
        ram_raddr   = head_reg;
        res_valid   = 1'b0;
        unique case (state_reg)
            fbq_pkg::S_IDLE: begin
                if (accept) begin
                    key_next    = in_key;
                    status_next = fbq_pkg::STAT_DONE;
                    gone_next   = '0;
                    cur_next    = '0;
                    unique case (in_kind)
                        fbq_pkg::KIND_APPEND: begin
                            if (full) begin
                                status_next = fbq_pkg::STAT_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = head_reg + count_reg[fbq_pkg::IDX_W-1:0];
                                count_next = count_reg + fbq_pkg::cnt_t'(1);
                            end
                        end
                        fbq_pkg::KIND_PRIORITY: begin
                            if (full) begin
                                status_next = fbq_pkg::STAT_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = head_reg - fbq_pkg::idx_t'(1);
                                head_next  = head_reg - fbq_pkg::idx_t'(1);
                                count_next = count_reg + fbq_pkg::cnt_t'(1);
                            end
                        end
                        fbq_pkg::KIND_POP, fbq_pkg::KIND_CANCEL: begin
                            if (count_reg == '0) begin
                                status_next = fbq_pkg::STAT_EMPTY;
                            end else begin
                                ram_re = 1'b1;
                            end
                        end
                        default: status_next = fbq_pkg::STAT_DONE;
                    endcase
                end
            end
            fbq_pkg::S_POP: begin
                gone_next  = ram_rdata;
                head_next  = head_reg + fbq_pkg::idx_t'(1);
                count_next = count_reg - fbq_pkg::cnt_t'(1);
            end
            fbq_pkg::S_SEARCH: begin
                if (match) begin
                    gone_next = ram_rdata;
                    if (more_search) begin
                        ram_re    = 1'b1;
                        ram_raddr = head_reg + cur_idx + fbq_pkg::idx_t'(1);
                    end else begin
                        count_next = count_reg - fbq_pkg::cnt_t'(1);
                    end
                end else if (more_search) begin
                    ram_re    = 1'b1;
                    ram_raddr = head_reg + cur_idx + fbq_pkg::idx_t'(1);
                    cur_next  = cur_reg + fbq_pkg::cnt_t'(1);
                end else begin
                    status_next = fbq_pkg::STAT_NOT_FOUND;
                end
            end
            fbq_pkg::S_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = head_reg + cur_idx;
                ram_wdata = ram_rdata;
                if (more_shift) begin
                    ram_re    = 1'b1;
                    ram_raddr = head_reg + cur_idx + fbq_pkg::idx_t'(2);
                    cur_next  = cur_reg + fbq_pkg::cnt_t'(1);
                end else begin
                    count_next = count_reg - fbq_pkg::cnt_t'(1);
                end
            end
            fbq_pkg::S_RESULT: begin
                res_valid = 1'b1;
            end
            default: res_valid = 1'b0;
        endcase
    end

    assign res = '{status: status_reg, removed: gone_reg, count: count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fbq_pkg::S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            max_reg   <= fbq_pkg::MAX_W'(fbq_pkg::MAX_RESET);
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cfg_we) begin
                max_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        gone_reg   <= gone_next;
    end

endmodule

`default_nettype wire

>>> sv/fbq_out.sv
`default_nettype none

module fbq_out (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          res_valid,
    output      logic                          res_ready,
    input  wire fbq_pkg::result_t              res,
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    output      logic [fbq_pkg::M_DATA_W-1:0]  m_tdata,
    output      logic [fbq_pkg::STAT_W-1:0]    m_tuser
);

    logic             valid_reg;
    fbq_pkg::result_t data_reg;

    assign res_ready = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_tuser   = data_reg.status;
    assign m_tdata   = fbq_pkg::M_DATA_W'({data_reg.count, data_reg.removed.plate,
                                           data_reg.removed.model, data_reg.removed.name});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            data_reg <= res;
        end
    end

endmodule

`default_nettype wire

>>> sv/front_back_queue_with_cancel_core.sv
// Channel   Dir  tdata (low bit up)                                   tuser
// s_*       in   name_code, model_code, plate_code                    kind
// m_*       out  removed_name, removed_model, removed_plate, count    status
// cfg_*     in   max_entries (cfg_wdata, written when cfg_we is high)  -
//
// One item in flight. Append, priority insert, refusal and empty go straight to
// the result; pop passes through S_POP; cancel reads entries in turn through the
// single read port of the entry memory, then shifts later entries toward the head.
// Reset is synchronous on aresetn low; the entry memory needs no clearing.
// A result held in the output register does not block the next transfer in.
`default_nettype none

module front_back_queue_with_cancel_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [fbq_pkg::MAX_W-1:0]    cfg_wdata,
    input  wire logic                         s_tvalid,
    output      logic                         s_tready,
    // name_code, model_code, plate_code
    input  wire logic [fbq_pkg::S_DATA_W-1:0] s_tdata,
    // kind
    input  wire logic [fbq_pkg::KIND_W-1:0]   s_tuser,
    output      logic                         m_tvalid,
    input  wire logic                         m_tready,
    // removed_name, removed_model, removed_plate, entry_count
    output      logic [fbq_pkg::M_DATA_W-1:0] m_tdata,
    // status
    output      logic [fbq_pkg::STAT_W-1:0]   m_tuser
);

    fbq_pkg::entry_t  in_key;
    fbq_pkg::kind_t   in_kind;
    logic             res_valid;
    logic             res_ready;
    fbq_pkg::result_t res;
    logic             ram_we;
    fbq_pkg::idx_t    ram_waddr;
    fbq_pkg::entry_t  ram_wdata;
    logic             ram_re;
    fbq_pkg::idx_t    ram_raddr;
    fbq_pkg::entry_t  ram_rdata;

    assign in_key  = fbq_pkg::entry_t'(s_tdata[3*fbq_pkg::KEY_BITS-1:0]);
    assign in_kind = fbq_pkg::kind_t'(s_tuser);

    fbq_ram #(
        .WIDTH ($bits(fbq_pkg::entry_t)),
        .WORDS (fbq_pkg::DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fbq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (in_kind),
        .in_key    (in_key),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    fbq_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

>>> verif/tb_front_back_queue_with_cancel_core.sv
`timescale 1ns / 1ps

module tb_front_back_queue_with_cancel_core;
    import fbq_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [MAX_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic [KIND_W-1:0]   s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]   m_tuser;

    entry_t           mirror_entries[$];
    result_t          pending_replies[$];
    logic [MAX_W-1:0] limit_reg = MAX_W'(MAX_RESET);
    entry_t           key_pool[4];

    int      src_gap_odds  = 25;
    bit      tail_quiet    = 1'b0;
    int      sink_hold     = 0;
    int      cycle_count   = 0;
    int      err_count     = 0;
    int      ops_sent      = 0;
    int      replies_seen  = 0;
    int      cancel_hits   = 0;
    int      full_refusals = 0;
    int      key_misses    = 0;
    int      empty_hits    = 0;
    result_t want;

    front_back_queue_with_cancel_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d replies outstanding",
                 cycle_count, pending_replies.size());
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(string what, logic [31:0] seen, logic [31:0] wanted);
        $display("mismatch on %s: got %h, want %h (reply %0d, cycle %0d)",
                 what, seen, wanted, replies_seen, cycle_count);
        err_count++;
    endtask

    function automatic result_t apply_queue_op(kind_t kind, entry_t key);
        result_t r;
        int      lim;
        int      hit;
        r.status  = STAT_DONE;
        r.removed = '0;
        lim = (limit_reg == 0) ? 1 : ((int'(limit_reg) > DEPTH) ? DEPTH : int'(limit_reg));
        case (kind)
            KIND_APPEND, KIND_PRIORITY: begin
                if (mirror_entries.size() != 0 && mirror_entries.size() >= lim) begin
                    r.status = STAT_FULL;
                    full_refusals++;
                end else if (kind == KIND_APPEND) begin
                    mirror_entries.push_back(key);
                end else begin
                    mirror_entries.push_front(key);
                end
            end
            KIND_POP: begin
                if (mirror_entries.size() == 0) begin
                    r.status = STAT_EMPTY;
                    empty_hits++;
                end else begin
                    r.removed = mirror_entries.pop_front();
                end
            end
            default: begin
                hit = -1;
                foreach (mirror_entries[i]) begin
                    if (hit < 0 && mirror_entries[i] == key) hit = i;
                end
                if (mirror_entries.size() == 0) begin
                    r.status = STAT_EMPTY;
                    empty_hits++;
                end else if (hit < 0) begin
                    r.status = STAT_NOT_FOUND;
                    key_misses++;
                end else begin
                    r.removed = mirror_entries[hit];
                    mirror_entries.delete(hit);
                    cancel_hits++;
                end
            end
        endcase
        r.count = cnt_t'(mirror_entries.size());
        return r;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("unexpected reply", 32'(m_tuser), '0);
            end else begin
                want = pending_replies.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", 32'(m_tuser), 32'(want.status));
                if (m_tdata[0 +: KEY_BITS] !== want.removed.name)
                    report_mismatch("removed name", m_tdata[0 +: KEY_BITS], want.removed.name);
                if (m_tdata[KEY_BITS +: KEY_BITS] !== want.removed.model)
                    report_mismatch("removed model", m_tdata[KEY_BITS +: KEY_BITS],
                                    want.removed.model);
                if (m_tdata[2*KEY_BITS +: KEY_BITS] !== want.removed.plate)
                    report_mismatch("removed plate", m_tdata[2*KEY_BITS +: KEY_BITS],
                                    want.removed.plate);
                if (m_tdata[3*KEY_BITS +: CNT_W] !== want.count)
                    report_mismatch("entry count", 32'(m_tdata[3*KEY_BITS +: CNT_W]),
                                    32'(want.count));
            end
            replies_seen++;
        end
    end

    initial begin : sink_ready
        int run;
        forever begin
            @(posedge aclk);
            if (sink_hold != 0) begin
                m_tready <= 1'b0;
                run = sink_hold;
                sink_hold = 0;
            end else if (!tail_quiet && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                run = $urandom_range(1, 19);
            end else begin
                m_tready <= 1'b1;
                run = tail_quiet ? 1 : $urandom_range(1, 40);
            end
            repeat (run - 1) @(posedge aclk);
        end
    end

    task automatic idle_source(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic send_op(kind_t kind, entry_t key);
        if (src_gap_odds != 0 && $urandom_range(1, 100) <= src_gap_odds)
            idle_source($urandom_range(1, 19));
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= key;
        do @(posedge aclk); while (!s_tready);
        pending_replies.push_back(apply_queue_op(kind, key));
        ops_sent++;
    endtask

    task automatic wait_replies();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(logic [MAX_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        limit_reg = value;
    endtask

    function automatic entry_t random_key();
        entry_t k;
        k.name  = $urandom;
        k.model = $urandom;
        k.plate = $urandom;
        return k;
    endfunction

    function automatic entry_t near_key(entry_t k);
        int bitpos;
        bitpos = $urandom_range(0, KEY_BITS - 1);
        case ($urandom_range(0, 2))
            0:       k.name[bitpos]  = ~k.name[bitpos];
            1:       k.model[bitpos] = ~k.model[bitpos];
            default: k.plate[bitpos] = ~k.plate[bitpos];
        endcase
        return k;
    endfunction

    function automatic entry_t insert_key();
        if ($urandom_range(0, 9) < 3) return key_pool[$urandom_range(0, 3)];
        return random_key();
    endfunction

    function automatic entry_t cancel_key();
        entry_t k;
        int     sel;
        sel = $urandom_range(0, 99);
        if (mirror_entries.size() != 0 && sel < 85) begin
            k = mirror_entries[$urandom_range(0, mirror_entries.size() - 1)];
            return (sel < 70) ? k : near_key(k);
        end
        return (sel < 92) ? key_pool[$urandom_range(0, 3)] : random_key();
    endfunction

    task automatic random_ops(int n);
        int sel;
        repeat (n) begin
            sel = $urandom_range(0, 99);
            if (sel < 28)      send_op(KIND_APPEND, insert_key());
            else if (sel < 45) send_op(KIND_PRIORITY, insert_key());
            else if (sel < 65) send_op(KIND_POP, random_key());
            else               send_op(KIND_CANCEL, cancel_key());
            if (!tail_quiet && $urandom_range(0, 39) == 0) wait_replies();
        end
    endtask

    task automatic test_directed_ops();
        entry_t ka;
        entry_t kb;
        entry_t kc;
        ka = random_key();
        kb = random_key();
        kc = random_key();
        send_op(KIND_POP, ka);
        send_op(KIND_CANCEL, ka);
        send_op(KIND_APPEND, ka);
        send_op(KIND_CANCEL, kb);
        send_op(KIND_CANCEL, near_key(ka));
        send_op(KIND_CANCEL, ka);
        send_op(KIND_APPEND, '0);
        send_op(KIND_APPEND, '1);
        send_op(KIND_PRIORITY, kc);
        send_op(KIND_POP, '1);
        send_op(KIND_CANCEL, '1);
        send_op(KIND_CANCEL, '0);
        // duplicates: the copy nearest the head goes first
        send_op(KIND_APPEND, ka);
        send_op(KIND_APPEND, kb);
        send_op(KIND_APPEND, ka);
        send_op(KIND_CANCEL, ka);
        send_op(KIND_POP, '0);
        // removal of the tail entry behind a priority insert
        send_op(KIND_PRIORITY, kc);
        send_op(KIND_CANCEL, ka);
        send_op(KIND_POP, '0);
        send_op(KIND_POP, '0);
        send_op(KIND_POP, '0);
        wait_replies();
    endtask

    task automatic test_limit_extremes();
        write_limit(8'd0);
        send_op(KIND_APPEND, key_pool[0]);
        send_op(KIND_APPEND, key_pool[1]);
        send_op(KIND_PRIORITY, key_pool[1]);
        send_op(KIND_POP, '0);
        send_op(KIND_PRIORITY, key_pool[1]);
        wait_replies();
        write_limit(8'd1);
        send_op(KIND_APPEND, key_pool[2]);
        send_op(KIND_POP, '0);
        send_op(KIND_POP, '0);
        wait_replies();
        write_limit(8'd255);
        repeat (DEPTH) send_op($urandom_range(0, 1) ? KIND_APPEND : KIND_PRIORITY, insert_key());
        send_op(KIND_APPEND, random_key());
        send_op(KIND_PRIORITY, random_key());
        wait_replies();
        write_limit(8'(DEPTH));
        send_op(KIND_APPEND, random_key());
        wait_replies();
        // limit dropped below the present count
        write_limit(8'd3);
        send_op(KIND_PRIORITY, random_key());
        send_op(KIND_CANCEL, mirror_entries[$]);
        send_op(KIND_CANCEL, mirror_entries[60]);
        send_op(KIND_CANCEL, near_key(mirror_entries[0]));
        while (mirror_entries.size() != 0) send_op(KIND_CANCEL, cancel_key());
        wait_replies();
        write_limit(8'(MAX_RESET));
    endtask

    task automatic test_sink_hold_off();
        src_gap_odds = 0;
        sink_hold    = 400;
        repeat (16) send_op(KIND_APPEND, insert_key());
        repeat (16) send_op(KIND_CANCEL, cancel_key());
        wait_replies();
        src_gap_odds = 25;
    endtask

    task automatic test_random_mix();
        logic [MAX_W-1:0] phase_limits[6];
        phase_limits[0] = 8'($urandom_range(1, DEPTH));
        phase_limits[1] = 8'd2;
        phase_limits[2] = 8'(DEPTH);
        phase_limits[3] = 8'($urandom_range(4, 12));
        phase_limits[4] = 8'd0;
        phase_limits[5] = 8'd255;
        foreach (phase_limits[p]) begin
            write_limit(phase_limits[p]);
            src_gap_odds = (p % 3 == 0) ? 0 : 25;
            random_ops(85);
            wait_replies();
        end
        src_gap_odds = 25;
    endtask

    task automatic test_quiet_tail();
        write_limit(8'($urandom_range(6, 20)));
        tail_quiet   = 1'b1;
        src_gap_odds = 0;
        random_ops(110);
        wait_replies();
    endtask

    initial begin
        foreach (key_pool[i]) key_pool[i] = random_key();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_ops();
        test_limit_extremes();
        test_sink_hold_off();
        test_random_mix();
        test_quiet_tail();
        repeat (150) @(posedge aclk);
        if (pending_replies.size() != 0)
            report_mismatch("replies never delivered", pending_replies.size(), '0);
        $display("%0d queue operations sent, %0d replies checked in %0d cycles",
                 ops_sent, replies_seen, cycle_count);
        $display("cancel hits %0d, key misses %0d, full refusals %0d, empty ops %0d",
                 cancel_hits, key_misses, full_refusals, empty_hits);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", err_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
